/* rtl/core/least_loaded_server_selector_macros.svh */
// assertion macros for the least loaded server selector
// expects clk and arst_n in the scope of the module that includes it
`ifndef LEAST_LOADED_SERVER_SELECTOR_MACROS_SVH
`define LEAST_LOADED_SERVER_SELECTOR_MACROS_SVH

// same-cycle implication, idle during reset
`define LLS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, idle during reset
`define LLS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/lls_pkg.sv */
// shared types and constants for the least loaded server selector
// no dependencies
package lls_pkg;

	localparam int MAX_SERVERS = 8;
	localparam int IDX_W       = 3;
	localparam int SCAN_W      = 4;
	localparam int COUNT_W     = 24;
	localparam int REQ_W       = 16;
	localparam int SIU_W       = 4;

	localparam logic [2:0] MODE_PICK     = 3'd0;
	localparam logic [2:0] MODE_REPORT   = 3'd1;
	localparam logic [2:0] MODE_DONE_OK  = 3'd2;
	localparam logic [2:0] MODE_DONE_BAD = 3'd3;
	localparam logic [2:0] MODE_MARK     = 3'd4;

	localparam logic CFG_SERVERS_IN_USE = 1'b0;
	localparam logic CFG_CHECK_INTERVAL = 1'b1;

	typedef struct packed {
		logic [2:0]         mode;
		logic [IDX_W-1:0]   server_index;
		logic [COUNT_W-1:0] report_load;
		logic [COUNT_W-1:0] report_errors;
		logic               report_ok;
	} in_t;

	typedef struct packed {
		logic [IDX_W-1:0] chosen_server;
		logic             all_down;
		logic             healthcheck_due;
	} out_t;

	typedef struct packed {
		logic [COUNT_W-1:0] load;
		logic [COUNT_W-1:0] err;
		logic               down;
	} entry_t;

	typedef struct packed {
		logic               load_we;
		logic               err_we;
		logic               down_we;
		logic [IDX_W-1:0]   addr;
		logic [COUNT_W-1:0] load;
		logic [COUNT_W-1:0] err;
		logic               down;
	} tbl_wr_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_ERR,
		ST_SCAN,
		ST_CHARGE
	} state_t;

endpackage

/* rtl/core/lls_table.sv */
// per-server table: load count, error count and down flag
// one read port, one write port with per-field enables; uses lls_pkg
module lls_table (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [lls_pkg::IDX_W-1:0]    rd_addr,
	output lls_pkg::entry_t              rd_data,
	input  lls_pkg::tbl_wr_t             wr
);

	logic [lls_pkg::COUNT_W-1:0]     load_q [lls_pkg::MAX_SERVERS];
	logic [lls_pkg::COUNT_W-1:0]     err_q  [lls_pkg::MAX_SERVERS];
	logic [lls_pkg::MAX_SERVERS-1:0] down_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lls_pkg::MAX_SERVERS; i++) begin
				load_q[i] <= '0;
				err_q[i]  <= '0;
			end
			down_q <= '1;
		end else begin
			if (wr.load_we) begin
				load_q[wr.addr] <= wr.load;
			end
			if (wr.err_we) begin
				err_q[wr.addr] <= wr.err;
			end
			if (wr.down_we) begin
				down_q[wr.addr] <= wr.down;
			end
		end
	end

	assign rd_data.load = load_q[rd_addr];
	assign rd_data.err  = err_q[rd_addr];
	assign rd_data.down = down_q[rd_addr];

endmodule

/* rtl/core/lls_alu.sv */
// shared unit: candidate compare for the scan and saturating 24-bit increment
// uses lls_pkg
module lls_alu (
	input  lls_pkg::entry_t               cand,
	input  logic [lls_pkg::COUNT_W-1:0]   best_load,
	input  logic [lls_pkg::COUNT_W-1:0]   best_err,
	input  logic                          found,
	output logic                          take,
	input  logic [lls_pkg::COUNT_W-1:0]   inc_in,
	output logic [lls_pkg::COUNT_W-1:0]   inc_out
);

	logic lt_load;
	logic eq_load;
	logic lt_err;

	assign lt_load = cand.load < best_load;
	assign eq_load = cand.load == best_load;
	assign lt_err  = cand.err < best_err;
	assign take    = !cand.down && (!found || lt_load || (eq_load && lt_err));

	assign inc_out = (inc_in == '1) ? inc_in : inc_in + 1'b1;

endmodule

/* rtl/core/least_loaded_server_selector.sv */
// top level: command sequencer, config registers and request counter
// uses lls_pkg, lls_table, lls_alu and least_loaded_server_selector_macros.svh
//
// channel   ports                         transfer when
// -------   ----------------------------  -------------------------
// command   start, busy, cmd              start high and busy low
// result    done, result                  done high (one cycle)
// config    cfg_we, cfg_index, cfg_wdata  cfg_we high
//
// pick and repick: the exec state, then N scan states, then the charge state, N = servers scanned
// (min of servers_in_use and 8), one table entry per cycle through the shared compare unit
// health report and request done ok: result from the exec state; request done bad: from the error state after it
// reset: table to zero counts with every server down, no clearing pass
// result is never stalled; busy drops in the cycle done is shown
`include "least_loaded_server_selector_macros.svh"

module least_loaded_server_selector (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  lls_pkg::in_t        cmd,
	output logic                done,
	output lls_pkg::out_t       result,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_wdata
);

	lls_pkg::state_t                  state_q, state_d;
	lls_pkg::in_t                     item_q, item_d;
	lls_pkg::out_t                    result_q, result_d;
	logic                             done_q, done_d;
	logic [lls_pkg::SCAN_W-1:0]       scan_q, scan_d;
	logic [lls_pkg::IDX_W-1:0]        sel_q, sel_d;
	logic [lls_pkg::COUNT_W-1:0]      best_load_q, best_load_d;
	logic [lls_pkg::COUNT_W-1:0]      best_err_q, best_err_d;
	logic                             found_q, found_d;
	logic [lls_pkg::REQ_W-1:0]        req_q, req_d;
	logic [lls_pkg::SIU_W-1:0]        siu_q;
	logic [lls_pkg::REQ_W-1:0]        interval_q;

	logic [lls_pkg::SCAN_W-1:0]       limit;
	logic [lls_pkg::REQ_W-1:0]        req_inc;
	logic [lls_pkg::IDX_W-1:0]        rd_addr;
	lls_pkg::entry_t                  rd_data;
	lls_pkg::tbl_wr_t                 wr;
	logic                             take;
	logic [lls_pkg::COUNT_W-1:0]      inc_in;
	logic [lls_pkg::COUNT_W-1:0]      inc_out;

	lls_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr      (wr)
	);

	lls_alu u_alu (
		.cand      (rd_data),
		.best_load (best_load_q),
		.best_err  (best_err_q),
		.found     (found_q),
		.take      (take),
		.inc_in    (inc_in),
		.inc_out   (inc_out)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			siu_q      <= lls_pkg::SIU_W'(8);
			interval_q <= lls_pkg::REQ_W'(5);
		end else if (cfg_we) begin
			unique case (cfg_index)
				lls_pkg::CFG_SERVERS_IN_USE: siu_q <= cfg_wdata[lls_pkg::SIU_W-1:0];
				lls_pkg::CFG_CHECK_INTERVAL: interval_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign limit = (siu_q > lls_pkg::SIU_W'(lls_pkg::MAX_SERVERS))
		? lls_pkg::SCAN_W'(lls_pkg::MAX_SERVERS) : siu_q;
	assign req_inc = (req_q == '1) ? req_q : req_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lls_pkg::ST_IDLE;
			done_q  <= 1'b0;
			req_q   <= '0;
			found_q <= 1'b0;
			scan_q  <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			req_q   <= req_d;
			found_q <= found_d;
			scan_q  <= scan_d;
		end
	end

	always_ff @(posedge clk) begin
		item_q      <= item_d;
		result_q    <= result_d;
		sel_q       <= sel_d;
		best_load_q <= best_load_d;
		best_err_q  <= best_err_d;
	end

	always_comb begin
		state_d     = state_q;
		item_d      = item_q;
		result_d    = result_q;
		done_d      = 1'b0;
		scan_d      = scan_q;
		sel_d       = sel_q;
		best_load_d = best_load_q;
		best_err_d  = best_err_q;
		found_d     = found_q;
		req_d       = req_q;
		rd_addr     = item_q.server_index;
		inc_in      = rd_data.load;
		wr          = '0;
		wr.addr     = item_q.server_index;

		unique case (state_q)
			lls_pkg::ST_IDLE: begin
				if (start) begin
					item_d  = cmd;
					state_d = lls_pkg::ST_EXEC;
				end
			end
			lls_pkg::ST_EXEC: begin
				result_d = '0;
				scan_d   = '0;
				found_d  = 1'b0;
				sel_d    = '0;
				unique case (item_q.mode)
					lls_pkg::MODE_PICK: begin
						state_d = (limit == '0) ? lls_pkg::ST_CHARGE : lls_pkg::ST_SCAN;
					end
					lls_pkg::MODE_MARK: begin
						wr.down_we = 1'b1;
						wr.down    = 1'b1;
						state_d = (limit == '0) ? lls_pkg::ST_CHARGE : lls_pkg::ST_SCAN;
					end
					lls_pkg::MODE_REPORT: begin
						wr.down_we = 1'b1;
						wr.down    = !item_q.report_ok;
						wr.load_we = item_q.report_ok;
						wr.err_we  = item_q.report_ok;
						wr.load    = item_q.report_load;
						wr.err     = item_q.report_errors;
						done_d     = 1'b1;
						state_d    = lls_pkg::ST_IDLE;
					end
					lls_pkg::MODE_DONE_OK, lls_pkg::MODE_DONE_BAD: begin
						wr.load_we = 1'b1;
						wr.load    = inc_out;
						if (req_inc >= interval_q) begin
							req_d = '0;
							result_d.healthcheck_due = 1'b1;
						end else begin
							req_d = req_inc;
						end
						if (item_q.mode == lls_pkg::MODE_DONE_BAD) begin
							state_d = lls_pkg::ST_ERR;
						end else begin
							done_d  = 1'b1;
							state_d = lls_pkg::ST_IDLE;
						end
					end
					default: begin
						done_d  = 1'b1;
						state_d = lls_pkg::ST_IDLE;
					end
				endcase
			end
			lls_pkg::ST_ERR: begin
				inc_in    = rd_data.err;
				wr.err_we = 1'b1;
				wr.err    = inc_out;
				done_d    = 1'b1;
				state_d   = lls_pkg::ST_IDLE;
			end
			lls_pkg::ST_SCAN: begin
				rd_addr = scan_q[lls_pkg::IDX_W-1:0];
				if (take) begin
					sel_d       = scan_q[lls_pkg::IDX_W-1:0];
					best_load_d = rd_data.load;
					best_err_d  = rd_data.err;
					found_d     = 1'b1;
				end
				scan_d = scan_q + 1'b1;
				if (scan_q == limit - 1'b1) begin
					state_d = lls_pkg::ST_CHARGE;
				end
			end
			lls_pkg::ST_CHARGE: begin
				rd_addr    = found_q ? sel_q : '0;
				wr.addr    = rd_addr;
				wr.load_we = 1'b1;
				wr.load    = inc_out;
				result_d.chosen_server = rd_addr;
				result_d.all_down      = !found_q;
				done_d     = 1'b1;
				state_d    = lls_pkg::ST_IDLE;
			end
			default: begin
				state_d = lls_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy   = state_q != lls_pkg::ST_IDLE;
	assign done   = done_q;
	assign result = result_q;

	`LLS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted command did not raise busy")
	`LLS_ASSERT_NOW(a_done_after_busy, done, $past(busy), "result without a command in flight")
	`LLS_ASSERT_NOW(a_down_chosen_zero, done && result.all_down, result.chosen_server == '0,
		"all_down with nonzero server")
	`LLS_ASSERT_NOW(a_due_alone, done && result.healthcheck_due,
		result.chosen_server == '0 && !result.all_down, "healthcheck_due mixed with a pick")

endmodule
